[rtl/radio_link_selector_core_defines.svh]
`ifndef RADIO_LINK_SELECTOR_CORE_DEFINES_SVH
`define RADIO_LINK_SELECTOR_CORE_DEFINES_SVH

// same-cycle implication
`define RLS_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rls: same-cycle check failed");

// next-cycle implication
`define RLS_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rls: next-cycle check failed");

`endif

[rtl/rls_pkg.sv]
package rls_pkg;

   localparam int unsigned STEP_W  = 5;
   localparam int unsigned SCORE_W = 19;
   localparam int unsigned DIV_W   = 16;
   localparam int unsigned CNT_W   = 4;

   localparam logic [1:0] FUNC_UPDATE = 2'd0;
   localparam logic [1:0] FUNC_QUERY  = 2'd1;
   localparam logic [1:0] FUNC_CLEAR  = 2'd2;

   localparam logic [1:0] LINK_WIFI = 2'd0;
   localparam logic [1:0] LINK_BLE  = 2'd1;
   localparam logic [1:0] LINK_LORA = 2'd2;

   localparam logic [2:0] MODE_WIFI      = 3'd0;
   localparam logic [2:0] MODE_BLE       = 3'd1;
   localparam logic [2:0] MODE_LORA      = 3'd2;
   localparam logic [2:0] MODE_LAST      = 3'd3;
   localparam logic [2:0] MODE_FASTEST   = 3'd4;
   localparam logic [2:0] MODE_STRONGEST = 3'd5;
   localparam logic [2:0] MODE_ADAPTIVE  = 3'd6;

   localparam logic REG_STRATEGY = 1'b0;
   localparam logic REG_WINDOW   = 1'b1;

   localparam logic [2:0]  STRATEGY_RESET = MODE_ADAPTIVE;
   localparam logic [31:0] WINDOW_RESET   = 32'd300000;

   localparam logic [15:0]               SUCCESS_SCALE = 16'd40000;
   localparam logic signed [SCORE_W-1:0] RECENT_BONUS  = 19'sd20000;
   localparam logic signed [SCORE_W-1:0] SIG_OFFSET    = 19'sd100;
   localparam logic signed [SCORE_W-1:0] SIG_WEIGHT    = 19'sd200;
   localparam logic [14:0]               SPEED_BASE    = 15'd20000;
   localparam logic [15:0]               SPEED_LIMIT   = 16'd10000;

   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_W - 1);

   typedef enum logic [3:0] {
      OP_WAIT,
      OP_NOP,
      OP_MUL,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_SCORE,
      OP_PICK_ADAPT,
      OP_PICK_SIMPLE,
      OP_POST,
      OP_UPDATE,
      OP_CLEAR
   } op_type;

   typedef enum logic [3:0] {
      COND_NEXT,
      COND_GOTO,
      COND_NO_REQ,
      COND_IS_UPDATE,
      COND_IS_CLEAR,
      COND_NOT_QUERY,
      COND_NOT_ADAPT,
      COND_DIV_MORE,
      COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type             op;
      logic               link;
      cond_type           cond;
      logic [STEP_W-1:0]  target;
   } ctrl_word_type;

   typedef struct packed {
      logic is_update;
      logic is_clear;
      logic is_query;
      logic is_adapt;
   } dp_flags_type;

   typedef struct packed {
      logic         req_fire;
      dp_flags_type flags;
      logic         div_last;
      logic         out_busy;
   } seq_status_type;

   typedef struct packed {
      logic mul;
      logic init;
      logic step;
   } div_ctrl_type;

   localparam logic [STEP_W-1:0] S_WAIT     = 5'd0;
   localparam logic [STEP_W-1:0] S_DISP_UPD = 5'd1;
   localparam logic [STEP_W-1:0] S_DISP_CLR = 5'd2;
   localparam logic [STEP_W-1:0] S_DISP_QRY = 5'd3;
   localparam logic [STEP_W-1:0] S_DISP_MOD = 5'd4;
   localparam logic [STEP_W-1:0] S_MUL0     = 5'd5;
   localparam logic [STEP_W-1:0] S_INIT0    = 5'd6;
   localparam logic [STEP_W-1:0] S_DIV0     = 5'd7;
   localparam logic [STEP_W-1:0] S_SCORE0   = 5'd8;
   localparam logic [STEP_W-1:0] S_MUL1     = 5'd9;
   localparam logic [STEP_W-1:0] S_INIT1    = 5'd10;
   localparam logic [STEP_W-1:0] S_DIV1     = 5'd11;
   localparam logic [STEP_W-1:0] S_SCORE1   = 5'd12;
   localparam logic [STEP_W-1:0] S_ADAPT    = 5'd13;
   localparam logic [STEP_W-1:0] S_POST     = 5'd14;
   localparam logic [STEP_W-1:0] S_RETURN   = 5'd15;
   localparam logic [STEP_W-1:0] S_SIMPLE   = 5'd16;
   localparam logic [STEP_W-1:0] S_UPDATE   = 5'd17;
   localparam logic [STEP_W-1:0] S_CLEAR    = 5'd18;

   function automatic ctrl_word_type mk(input op_type op, input logic link,
                                        input cond_type cond,
                                        input logic [STEP_W-1:0] target);
      ctrl_word_type w;
      w.op     = op;
      w.link   = link;
      w.cond   = cond;
      w.target = target;
      return w;
   endfunction

   function automatic ctrl_word_type rom_word(input logic [STEP_W-1:0] step);
      ctrl_word_type w;
      case (step)
         S_WAIT:     w = mk(OP_WAIT,        1'b0, COND_NO_REQ,    S_WAIT);
         S_DISP_UPD: w = mk(OP_NOP,         1'b0, COND_IS_UPDATE, S_UPDATE);
         S_DISP_CLR: w = mk(OP_NOP,         1'b0, COND_IS_CLEAR,  S_CLEAR);
         S_DISP_QRY: w = mk(OP_NOP,         1'b0, COND_NOT_QUERY, S_WAIT);
         S_DISP_MOD: w = mk(OP_NOP,         1'b0, COND_NOT_ADAPT, S_SIMPLE);
         S_MUL0:     w = mk(OP_MUL,         1'b0, COND_NEXT,      S_WAIT);
         S_INIT0:    w = mk(OP_DIV_INIT,    1'b0, COND_NEXT,      S_WAIT);
         S_DIV0:     w = mk(OP_DIV_STEP,    1'b0, COND_DIV_MORE,  S_DIV0);
         S_SCORE0:   w = mk(OP_SCORE,       1'b0, COND_NEXT,      S_WAIT);
         S_MUL1:     w = mk(OP_MUL,         1'b1, COND_NEXT,      S_WAIT);
         S_INIT1:    w = mk(OP_DIV_INIT,    1'b1, COND_NEXT,      S_WAIT);
         S_DIV1:     w = mk(OP_DIV_STEP,    1'b1, COND_DIV_MORE,  S_DIV1);
         S_SCORE1:   w = mk(OP_SCORE,       1'b1, COND_NEXT,      S_WAIT);
         S_ADAPT:    w = mk(OP_PICK_ADAPT,  1'b0, COND_NEXT,      S_WAIT);
         S_POST:     w = mk(OP_POST,        1'b0, COND_OUT_BUSY,  S_POST);
         S_RETURN:   w = mk(OP_NOP,         1'b0, COND_GOTO,      S_WAIT);
         S_SIMPLE:   w = mk(OP_PICK_SIMPLE, 1'b0, COND_GOTO,      S_POST);
         S_UPDATE:   w = mk(OP_UPDATE,      1'b0, COND_GOTO,      S_WAIT);
         S_CLEAR:    w = mk(OP_CLEAR,       1'b0, COND_GOTO,      S_WAIT);
         default:    w = mk(OP_NOP,         1'b0, COND_GOTO,      S_WAIT);
      endcase
      return w;
   endfunction

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (&v) ? v : v + 32'd1;
   endfunction

endpackage

[rtl/radio_link_selector_core.sv]
// Update: dispatch steps, UPDATE, back to wait. Query, fixed strategies: dispatch steps,
// SIMPLE pick, POST to the result register, RETURN to wait. Adaptive query: per link MUL,
// INIT, the 16-step shared divider run and SCORE, then ADAPT pick, POST and RETURN.
// One transaction in flight; the result register frees the input while it waits.
// Synchronous reset zeroes both link records, strategy to adaptive, window 300000 ms.
`include "radio_link_selector_core_defines.svh"

module radio_link_selector_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_func,
   input  logic               req_link_id,
   input  logic               req_attempt_ok,
   input  logic [15:0]        req_connect_ms,
   input  logic signed [7:0]  req_signal_dbm,
   input  logic [31:0]        req_now_ms,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_best_link,
   output logic               rsp_fallback_link,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   rls_pkg::ctrl_word_type            ctrl;
   rls_pkg::seq_status_type           status;
   rls_pkg::dp_flags_type             flags;
   rls_pkg::div_ctrl_type             dctl;

   logic [2:0]                        strategy_ff;
   logic [2:0]                        strategy_in;
   logic [31:0]                       window_ff;
   logic [31:0]                       window_in;
   logic                              csr_wr;

   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic [1:0]                        rsp_best_ff;
   logic [1:0]                        rsp_best_in;
   logic                              rsp_fallback_ff;
   logic                              rsp_fallback_in;

   logic                              req_fire;
   logic                              out_busy;
   logic                              post;
   logic [31:0]                       numer;
   logic [31:0]                       denom;
   logic [rls_pkg::DIV_W-1:0]         quot;
   logic                              div_last;
   logic [1:0]                        best_link;

   assign req_ready = (ctrl.op == rls_pkg::OP_WAIT);
   assign req_fire  = req_valid && req_ready;
   assign out_busy  = rsp_valid_ff && !rsp_ready;
   assign post      = (ctrl.op == rls_pkg::OP_POST) && !out_busy;

   assign dctl.mul  = (ctrl.op == rls_pkg::OP_MUL);
   assign dctl.init = (ctrl.op == rls_pkg::OP_DIV_INIT);
   assign dctl.step = (ctrl.op == rls_pkg::OP_DIV_STEP);

   assign status.req_fire = req_fire;
   assign status.flags    = flags;
   assign status.div_last = div_last;
   assign status.out_busy = out_busy;

   rls_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   rls_div u_div (
      .clock (clock),
      .reset (reset),
      .dctl  (dctl),
      .numer (numer),
      .denom (denom),
      .quot  (quot),
      .last  (div_last)
   );

   rls_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .req_fire   (req_fire),
      .func       (req_func),
      .link_id    (req_link_id),
      .attempt_ok (req_attempt_ok),
      .connect_ms (req_connect_ms),
      .signal_dbm (req_signal_dbm),
      .now_ms     (req_now_ms),
      .strategy   (strategy_ff),
      .window     (window_ff),
      .quot       (quot),
      .numer      (numer),
      .denom      (denom),
      .flags      (flags),
      .best_link  (best_link)
   );

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      strategy_in = strategy_ff;
      window_in   = window_ff;
      if (csr_wr) begin
         if (csr_paddr[2] == rls_pkg::REG_WINDOW) begin
            window_in = csr_pwdata;
         end else begin
            strategy_in = csr_pwdata[2:0];
         end
      end
      csr_prdata = (csr_paddr[2] == rls_pkg::REG_STRATEGY) ? {29'd0, strategy_ff} : window_ff;
   end

   always_comb begin
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_best_in     = rsp_best_ff;
      rsp_fallback_in = rsp_fallback_ff;
      if (post) begin
         rsp_valid_in    = 1'b1;
         rsp_best_in     = best_link;
         rsp_fallback_in = (best_link == rls_pkg::LINK_WIFI);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strategy_ff  <= rls_pkg::STRATEGY_RESET;
         window_ff    <= rls_pkg::WINDOW_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         strategy_ff  <= strategy_in;
         window_ff    <= window_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_best_ff     <= rsp_best_in;
      rsp_fallback_ff <= rsp_fallback_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_best_link     = rsp_best_ff;
   assign rsp_fallback_link = rsp_fallback_ff;

   `RLS_ASSERT_IMP(a_rsp_from_post, clock, reset, $rose(rsp_valid_ff), $past(ctrl.op == rls_pkg::OP_POST))
   `RLS_ASSERT_IMP(a_fallback_pairs, clock, reset, rsp_valid_ff, rsp_fallback_ff == (rsp_best_ff == rls_pkg::LINK_WIFI))
   `RLS_ASSERT_NXT(a_accept_leaves_wait, clock, reset, req_fire, !req_ready)

endmodule

[rtl/rls_seq.sv]
module rls_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  rls_pkg::seq_status_type status,
   output rls_pkg::ctrl_word_type  ctrl
);

   logic [rls_pkg::STEP_W-1:0] step_ff;
   logic [rls_pkg::STEP_W-1:0] step_in;
   logic                       taken;

   assign ctrl = rls_pkg::rom_word(step_ff);

   always_comb begin
      case (ctrl.cond)
         rls_pkg::COND_NEXT:      taken = 1'b0;
         rls_pkg::COND_GOTO:      taken = 1'b1;
         rls_pkg::COND_NO_REQ:    taken = !status.req_fire;
         rls_pkg::COND_IS_UPDATE: taken = status.flags.is_update;
         rls_pkg::COND_IS_CLEAR:  taken = status.flags.is_clear;
         rls_pkg::COND_NOT_QUERY: taken = !status.flags.is_query;
         rls_pkg::COND_NOT_ADAPT: taken = !status.flags.is_adapt;
         rls_pkg::COND_DIV_MORE:  taken = !status.div_last;
         rls_pkg::COND_OUT_BUSY:  taken = status.out_busy;
         default:                 taken = 1'b1;
      endcase
      step_in = taken ? ctrl.target : step_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= rls_pkg::S_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

[rtl/rls_div.sv]
module rls_div (
   input  logic                       clock,
   input  logic                       reset,
   input  rls_pkg::div_ctrl_type      dctl,
   input  logic [31:0]                numer,
   input  logic [31:0]                denom,
   output logic [rls_pkg::DIV_W-1:0]  quot,
   output logic                       last
);

   logic [47:0]                 prod_ff;
   logic [47:0]                 prod_in;
   logic [31:0]                 den_ff;
   logic [31:0]                 den_in;
   logic [31:0]                 rem_ff;
   logic [31:0]                 rem_in;
   logic [rls_pkg::DIV_W-1:0]   acc_ff;
   logic [rls_pkg::DIV_W-1:0]   acc_in;
   logic [rls_pkg::CNT_W-1:0]   cnt_ff;
   logic [rls_pkg::CNT_W-1:0]   cnt_in;
   logic [32:0]                 trial;
   logic [32:0]                 diff;
   logic                        ge;

   always_comb begin
      prod_in = prod_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      trial   = {rem_ff, acc_ff[rls_pkg::DIV_W-1]};
      diff    = trial - {1'b0, den_ff};
      ge      = trial >= {1'b0, den_ff};
      if (dctl.mul) begin
         prod_in = 48'(numer) * 48'(rls_pkg::SUCCESS_SCALE);
         den_in  = denom;
      end
      if (dctl.init) begin
         rem_in = prod_ff[47:rls_pkg::DIV_W];
         acc_in = prod_ff[rls_pkg::DIV_W-1:0];
         cnt_in = '0;
      end
      if (dctl.step) begin
         rem_in = ge ? diff[31:0] : trial[31:0];
         acc_in = {acc_ff[rls_pkg::DIV_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      prod_ff <= prod_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      acc_ff  <= acc_in;
   end

   assign quot = acc_ff;
   assign last = (cnt_ff == rls_pkg::DIV_LAST);

endmodule

[rtl/rls_dp.sv]
module rls_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  rls_pkg::ctrl_word_type      ctrl,
   input  logic                        req_fire,
   input  logic [1:0]                  func,
   input  logic                        link_id,
   input  logic                        attempt_ok,
   input  logic [15:0]                 connect_ms,
   input  logic signed [7:0]           signal_dbm,
   input  logic [31:0]                 now_ms,
   input  logic [2:0]                  strategy,
   input  logic [31:0]                 window,
   input  logic [rls_pkg::DIV_W-1:0]   quot,
   output logic [31:0]                 numer,
   output logic [31:0]                 denom,
   output rls_pkg::dp_flags_type       flags,
   output logic [1:0]                  best_link
);

   logic [1:0]         func_ff;
   logic               link_ff;
   logic               ok_ff;
   logic [15:0]        ct_ff;
   logic signed [7:0]  sig_ff;
   logic [31:0]        now_ff;

   logic [31:0]        succ_ff  [2];
   logic [31:0]        succ_in  [2];
   logic [31:0]        fail_ff  [2];
   logic [31:0]        fail_in  [2];
   logic [31:0]        att_ff   [2];
   logic [31:0]        att_in   [2];
   logic [15:0]        mean_ff  [2];
   logic [15:0]        mean_in  [2];
   logic signed [7:0]  lsig_ff  [2];
   logic signed [7:0]  lsig_in  [2];
   logic [31:0]        stamp_ff [2];
   logic [31:0]        stamp_in [2];

   logic signed [rls_pkg::SCORE_W-1:0] score_ff [2];
   logic signed [rls_pkg::SCORE_W-1:0] score_in [2];
   logic [1:0]                         best_ff;
   logic [1:0]                         best_in;

   logic [19:0]                        mix;
   logic [rls_pkg::DIV_W-1:0]          ratio;
   logic [31:0]                        age;
   logic                               recent;
   logic signed [rls_pkg::SCORE_W-1:0] sig_ext;
   logic signed [rls_pkg::SCORE_W-1:0] sig_term;
   logic [14:0]                        speed;
   logic signed [rls_pkg::SCORE_W-1:0] score;

   always_comb begin
      mix = 20'(mean_ff[link_ff]) * 20'd7 + 20'(ct_ff);
      for (int k = 0; k < 2; k++) begin
         succ_in[k]  = succ_ff[k];
         fail_in[k]  = fail_ff[k];
         att_in[k]   = att_ff[k];
         mean_in[k]  = mean_ff[k];
         lsig_in[k]  = lsig_ff[k];
         stamp_in[k] = stamp_ff[k];
         if (ctrl.op == rls_pkg::OP_CLEAR) begin
            succ_in[k]  = '0;
            fail_in[k]  = '0;
            att_in[k]   = '0;
            mean_in[k]  = '0;
            lsig_in[k]  = '0;
            stamp_in[k] = '0;
         end else if (ctrl.op == rls_pkg::OP_UPDATE && link_ff == 1'(k)) begin
            att_in[k]  = rls_pkg::sat_inc(att_ff[k]);
            lsig_in[k] = sig_ff;
            if (ok_ff) begin
               succ_in[k]  = rls_pkg::sat_inc(succ_ff[k]);
               stamp_in[k] = now_ff;
               mean_in[k]  = (mean_ff[k] == 16'd0) ? ct_ff : mix[18:3];
            end else begin
               fail_in[k] = rls_pkg::sat_inc(fail_ff[k]);
            end
         end
      end
   end

   always_comb begin
      ratio    = (att_ff[ctrl.link] == 32'd0) ? '0 : quot;
      age      = now_ff - stamp_ff[ctrl.link];
      recent   = (stamp_ff[ctrl.link] != 32'd0) && (age < window);
      sig_ext  = rls_pkg::SCORE_W'(lsig_ff[ctrl.link]);
      sig_term = (sig_ext + rls_pkg::SIG_OFFSET) * rls_pkg::SIG_WEIGHT;
      speed    = '0;
      if (mean_ff[ctrl.link] != 16'd0 && mean_ff[ctrl.link] < rls_pkg::SPEED_LIMIT) begin
         speed = rls_pkg::SPEED_BASE - {mean_ff[ctrl.link][13:0], 1'b0};
      end
      score = signed'(rls_pkg::SCORE_W'(ratio))
            + (recent ? rls_pkg::RECENT_BONUS : '0)
            + sig_term
            + signed'(rls_pkg::SCORE_W'(speed));
   end

   always_comb begin
      score_in[0] = score_ff[0];
      score_in[1] = score_ff[1];
      best_in     = best_ff;
      case (ctrl.op)
         rls_pkg::OP_SCORE: begin
            score_in[ctrl.link] = score;
         end
         rls_pkg::OP_PICK_ADAPT: begin
            best_in = (score_ff[0] > score_ff[1]) ? rls_pkg::LINK_WIFI : rls_pkg::LINK_BLE;
         end
         rls_pkg::OP_PICK_SIMPLE: begin
            case (strategy)
               rls_pkg::MODE_WIFI: best_in = rls_pkg::LINK_WIFI;
               rls_pkg::MODE_BLE:  best_in = rls_pkg::LINK_BLE;
               rls_pkg::MODE_LORA: best_in = rls_pkg::LINK_LORA;
               rls_pkg::MODE_LAST: begin
                  best_in = (stamp_ff[0] > stamp_ff[1]) ?
                            rls_pkg::LINK_WIFI : rls_pkg::LINK_BLE;
               end
               rls_pkg::MODE_FASTEST: begin
                  best_in = (mean_ff[0] < mean_ff[1]) ?
                            rls_pkg::LINK_WIFI : rls_pkg::LINK_BLE;
               end
               rls_pkg::MODE_STRONGEST: begin
                  best_in = (lsig_ff[0] > lsig_ff[1]) ?
                            rls_pkg::LINK_WIFI : rls_pkg::LINK_BLE;
               end
               default: best_in = best_ff;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 2; k++) begin
            succ_ff[k]  <= '0;
            fail_ff[k]  <= '0;
            att_ff[k]   <= '0;
            mean_ff[k]  <= '0;
            lsig_ff[k]  <= '0;
            stamp_ff[k] <= '0;
         end
      end else begin
         for (int k = 0; k < 2; k++) begin
            succ_ff[k]  <= succ_in[k];
            fail_ff[k]  <= fail_in[k];
            att_ff[k]   <= att_in[k];
            mean_ff[k]  <= mean_in[k];
            lsig_ff[k]  <= lsig_in[k];
            stamp_ff[k] <= stamp_in[k];
         end
      end
      if (ctrl.op == rls_pkg::OP_WAIT && req_fire) begin
         func_ff <= func;
         link_ff <= link_id;
         ok_ff   <= attempt_ok;
         ct_ff   <= connect_ms;
         sig_ff  <= signal_dbm;
         now_ff  <= now_ms;
      end
      score_ff[0] <= score_in[0];
      score_ff[1] <= score_in[1];
      best_ff     <= best_in;
   end

   assign numer           = succ_ff[ctrl.link];
   assign denom           = att_ff[ctrl.link];
   assign flags.is_update = (func_ff == rls_pkg::FUNC_UPDATE);
   assign flags.is_clear  = (func_ff == rls_pkg::FUNC_CLEAR);
   assign flags.is_query  = (func_ff == rls_pkg::FUNC_QUERY);
   assign flags.is_adapt  = (strategy >= rls_pkg::MODE_ADAPTIVE);
   assign best_link       = best_ff;

endmodule
